// ===== rtl/lrg_pkg.sv =====
// Shared types, widths and codes of the linear ramp generator.
// No dependencies; every other file of the block imports this package.

package lrg_pkg;

  // Field and register widths
  localparam int VALUE_BITS  = 32;
  localparam int LENGTH_BITS = 24;
  localparam int FRAC_BITS   = 16;
  localparam int ACC_BITS    = VALUE_BITS + FRAC_BITS;  // Q32.16 level and step
  localparam int VSIZE_BITS  = 13;
  localparam int PROD_BITS   = ACC_BITS + VSIZE_BITS;   // step times vector size
  localparam int SUM_BITS    = PROD_BITS + 1;           // level plus increment
  localparam int CNT_BITS    = $clog2(ACC_BITS);
  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 3;

  // Operation codes
  localparam logic [2:0] OP_TICK       = 3'd0;
  localparam logic [2:0] OP_LOAD_DEST  = 3'd1;
  localparam logic [2:0] OP_START      = 3'd2;
  localparam logic [2:0] OP_LOAD_LEVEL = 3'd3;
  localparam logic [2:0] OP_STOP       = 3'd4;

  // Register indexes, taken from paddr bit 2
  localparam logic REG_VECTOR_MODE = 1'b0;
  localparam logic REG_VECTOR_SIZE = 1'b1;

  localparam logic             VMODE_RESET = 1'b1;
  localparam logic [VSIZE_BITS-1:0] VSIZE_RESET = VSIZE_BITS'(64);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CLAMP,
    ST_PREP,
    ST_DIV,
    ST_STEP,
    ST_RESULT
  } ctl_state_t;

endpackage

// ===== rtl/lrg_if.sv =====
// Valid/ready channel interfaces for event words in and level words out.
// Depends on lrg_pkg for the field widths.

interface lrg_in_if import lrg_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic [2:0]                    op;
  logic signed [VALUE_BITS-1:0]  value;
  logic [LENGTH_BITS-1:0]        ramp_length;

  modport source (output valid, op, value, ramp_length, input ready);
  modport sink   (input valid, op, value, ramp_length, output ready);
endinterface

interface lrg_out_if import lrg_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_BITS-1:0]  level;
  logic                          ramping;

  modport source (output valid, level, ramping, input ready);
  modport sink   (input valid, level, ramping, output ready);
endinterface

// ===== rtl/linear_ramp_generator_core.sv =====
// Linear ramp generator with clamp at the destination: top level.
// Depends on lrg_pkg and the channel interfaces in lrg_if.sv.
//
//   channel   direction  handshake          word
//   in_if     sink       valid/ready        op, value, ramp_length
//   out_if    source     valid/ready        level, ramping
//   cfg_*     slave      APB, pready high   vector_mode @0x0, vector_size @0x4
//
// One event word is taken at a time; each one yields exactly one level word.
// Path from acceptance to the output register: loads, stop, unused codes, a zero-length
// start and a tick with no active step go straight to the result state; a tick with a
// step runs the shift-add multiplier over the 13 vector-size bits, then clamps; a start
// runs prep, the restoring divider (one quotient bit per cycle, 48 bits), then step.
// in_if.ready is high only while idle; a word waiting in the output register does not
// block acceptance, the next result simply holds in its final state until the slot frees.
// rst_n is synchronous: level, step, destination and direction clear, the registers
// return to vector mode with a vector size of 64.

module linear_ramp_generator_core
  import lrg_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  lrg_in_if.sink                   in_if,
  lrg_out_if.source                out_if,
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [APB_ADDR_BITS-1:0] cfg_paddr,
  input  logic [APB_DATA_BITS-1:0] cfg_pwdata,
  output logic [APB_DATA_BITS-1:0] cfg_prdata,
  output logic                     cfg_pready
);

  // Architectural state
  logic signed [ACC_BITS-1:0]   level_r;
  logic signed [ACC_BITS-1:0]   step_r;
  logic signed [VALUE_BITS-1:0] target_r;
  logic                         falling_r;
  logic                         vmode_r;
  logic [VSIZE_BITS-1:0]        vsize_r;

  // Sequencer
  ctl_state_t state_r, state_nxt;
  logic [CNT_BITS-1:0] cnt_r;

  // Multiplier and divider working registers
  logic signed [PROD_BITS-1:0]  prod_r;
  logic [VSIZE_BITS-1:0]        mlt_r;
  logic signed [ACC_BITS:0]     diff_r;
  logic [ACC_BITS-1:0]          mag_r;
  logic [LENGTH_BITS-1:0]       rem_r;
  logic [LENGTH_BITS-1:0]       len_r;
  logic                         neg_r;
  logic                         nz_r;

  // Output register
  logic                         out_valid_r;
  logic signed [VALUE_BITS-1:0] out_level_r;
  logic                         out_ramping_r;

  logic accept;
  logic in_ready;
  logic out_load;
  logic cfg_write;

  logic signed [ACC_BITS-1:0]   dest_acc;
  logic signed [PROD_BITS-1:0]  step_ext;
  logic signed [PROD_BITS-1:0]  prod_nxt;
  logic signed [SUM_BITS-1:0]   next_sum;
  logic signed [SUM_BITS-1:0]   dest_sum;
  logic                         hit;
  logic [LENGTH_BITS:0]         trial;
  logic [LENGTH_BITS:0]         trial_sub;
  logic                         trial_ge;
  logic [ACC_BITS:0]            diff_abs;
  logic [ACC_BITS-1:0]          q_step;

  assign dest_acc = {target_r, {FRAC_BITS{1'b0}}};
  assign accept   = in_if.valid & in_ready;

  // ---------------------------------------------------------------------------
  // Configuration port: registers written in the access phase, read at any time
  // ---------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_comb begin
    case (cfg_paddr[2])
      REG_VECTOR_MODE: cfg_prdata = APB_DATA_BITS'(vmode_r);
      REG_VECTOR_SIZE: cfg_prdata = APB_DATA_BITS'(vsize_r);
      default:         cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vmode_r <= VMODE_RESET;
      vsize_r <= VSIZE_RESET;
    end else if (cfg_write) begin
      case (cfg_paddr[2])
        REG_VECTOR_MODE: vmode_r <= cfg_pwdata[0];
        REG_VECTOR_SIZE: vsize_r <= cfg_pwdata[VSIZE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_if.op)
            OP_TICK:  state_nxt = (step_r != '0) ? ST_MUL : ST_RESULT;
            OP_START: state_nxt = (in_if.ramp_length == '0) ? ST_RESULT : ST_PREP;
            default:  state_nxt = ST_RESULT;
          endcase
        end
      end
      ST_MUL:    if (cnt_r == '0) state_nxt = ST_CLAMP;
      ST_CLAMP:  state_nxt = ST_RESULT;
      ST_PREP:   state_nxt = ST_DIV;
      ST_DIV:    if (cnt_r == '0) state_nxt = ST_STEP;
      ST_STEP:   state_nxt = ST_RESULT;
      ST_RESULT: if (out_load) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    case (state_r)
      ST_IDLE:   in_ready = 1'b1;
      ST_RESULT: out_load = ~out_valid_r | out_if.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // ---------------------------------------------------------------------------
  // Datapath helpers
  // ---------------------------------------------------------------------------
  // Shift-add, most significant multiplier bit first
  assign step_ext = PROD_BITS'(step_r);
  assign prod_nxt = (prod_r <<< 1) + (mlt_r[VSIZE_BITS-1] ? step_ext : '0);

  // Clamp test against the destination in the ramp's direction
  assign next_sum = SUM_BITS'(level_r) + SUM_BITS'(prod_r);
  assign dest_sum = SUM_BITS'(dest_acc);
  assign hit      = falling_r ? (next_sum <= dest_sum) : (next_sum >= dest_sum);

  // One restoring division step: remainder is always below the divisor
  assign trial     = {rem_r, mag_r[ACC_BITS-1]};
  assign trial_sub = trial - {1'b0, len_r};
  assign trial_ge  = trial >= {1'b0, len_r};

  // take the sign straight from the distance: neg_r is only loaded alongside
  assign diff_abs = diff_r[ACC_BITS] ? -diff_r : diff_r;

  // Signed step from the quotient magnitude: saturate, and never let a nonzero
  // distance give a zero step
  always_comb begin
    if (mag_r[ACC_BITS-1]) begin
      q_step = neg_r ? {1'b1, {(ACC_BITS-1){1'b0}}} : {1'b0, {(ACC_BITS-1){1'b1}}};
    end else if (mag_r == '0) begin
      if (!nz_r)      q_step = '0;
      else if (neg_r) q_step = '1;
      else            q_step = ACC_BITS'(1);
    end else begin
      q_step = neg_r ? -mag_r : mag_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Architectural state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r   <= '0;
      step_r    <= '0;
      target_r  <= '0;
      falling_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            case (in_if.op)
              OP_LOAD_DEST:  target_r <= in_if.value;
              OP_LOAD_LEVEL: level_r  <= {in_if.value, {FRAC_BITS{1'b0}}};
              OP_STOP:       step_r   <= '0;
              OP_START: begin
                // zero length jumps straight to the destination
                if (in_if.ramp_length == '0) begin
                  level_r   <= dest_acc;
                  step_r    <= '0;
                  falling_r <= 1'b0;
                end
              end
              default: ;
            endcase
          end
        end
        ST_CLAMP: begin
          if (hit) begin
            level_r <= dest_acc;
            step_r  <= '0;
          end else begin
            level_r <= next_sum[ACC_BITS-1:0];
          end
        end
        ST_STEP: begin
          step_r    <= q_step;
          falling_r <= neg_r;
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Working registers of the multiplier and divider (no reset needed)
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          // load both units; only the one the state machine enters is used
          mlt_r  <= vmode_r ? vsize_r : VSIZE_BITS'(1);
          prod_r <= '0;
          cnt_r  <= CNT_BITS'(VSIZE_BITS - 1);
          diff_r <= (ACC_BITS+1)'(dest_acc) - (ACC_BITS+1)'(level_r);
          len_r  <= in_if.ramp_length;
        end
      end
      ST_MUL: begin
        prod_r <= prod_nxt;
        mlt_r  <= mlt_r << 1;
        cnt_r  <= cnt_r - 1'b1;
      end
      ST_PREP: begin
        neg_r <= diff_r[ACC_BITS];
        nz_r  <= diff_r != '0;
        rem_r <= '0;
        cnt_r <= CNT_BITS'(ACC_BITS - 1);
      end
      ST_DIV: begin
        rem_r <= trial_ge ? trial_sub[LENGTH_BITS-1:0] : trial[LENGTH_BITS-1:0];
        mag_r <= {mag_r[ACC_BITS-2:0], trial_ge};
        cnt_r <= cnt_r - 1'b1;
      end
      default: ;
    endcase
    // magnitude of the distance enters the dividend shift register
    if (state_r == ST_PREP) mag_r <= diff_abs[ACC_BITS-1:0];
  end

  // ---------------------------------------------------------------------------
  // Output register: hold the word until taken, refill from the result state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_level_r   <= level_r[ACC_BITS-1:FRAC_BITS];
      out_ramping_r <= step_r != '0;
    end
  end

  assign in_if.ready    = in_ready;
  assign out_if.valid   = out_valid_r;
  assign out_if.level   = out_level_r;
  assign out_if.ramping = out_ramping_r;

endmodule

// ===== rtl/lrg_checker.sv =====
// Port-level checks on the ramp generator, attached to the top level by bind.
// Depends on lrg_pkg and linear_ramp_generator_core.

module lrg_checker
  import lrg_pkg::*;
(
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic signed [VALUE_BITS-1:0] out_level,
  input logic                         out_ramping,
  input logic                         cfg_pready
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_level) && $stable(out_ramping))
    else $error("output word changed while stalled");

  // one event at a time: an accepted word closes the input
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on consecutive cycles");

  // a fresh result only appears while the block is busy with an event
  a_result_after_event: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result word without a pending event");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("configuration port inserted a wait state");

endmodule

bind linear_ramp_generator_core lrg_checker u_lrg_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_if.valid),
  .in_ready    (in_if.ready),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .out_level   (out_if.level),
  .out_ramping (out_if.ramping),
  .cfg_pready  (cfg_pready)
);
